// ===== sv/vgps_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel grid point sampler package
// Shared widths, register indexes and the lane control type.
// ----------------------------------------------------------------------------
package vgps_pkg;

    localparam int GRID_BITS   = 7;
    localparam int STAMP_WIDTH = 16;
    localparam int FRAC_BITS   = 16;

    localparam int CELL_BITS  = 3 * GRID_BITS;
    localparam int CELL_COUNT = 1 << CELL_BITS;

    localparam int COORD_W    = 32;
    localparam int COUNT_W    = 32;
    localparam int SCALE_W    = 40;
    localparam int SCALE_FRAC = 32;
    localparam int SCALE_HI_W = SCALE_W - SCALE_FRAC;
    localparam int LIMIT_W    = 18;
    localparam int SMALL_W    = 16;

    // Integer part of the position: product of the high scale byte plus carry
    localparam int IP_W  = COORD_W + SCALE_HI_W + 1;
    localparam int AL_W  = FRAC_BITS + 1;
    localparam int SQ_W  = 2 * AL_W;
    localparam int DSQ_W = SQ_W + 2;
    localparam int CMP_W = (DSQ_W > LIMIT_W + FRAC_BITS) ? DSQ_W : LIMIT_W + FRAC_BITS;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SCALE_W;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SMALL_LIM  = 3'd7;

    localparam logic [SCALE_W-1:0] SCALE_RESET       = 40'h01_0000_0000;
    localparam logic [LIMIT_W-1:0] DIST_LIMIT_RESET  = 18'd96338;
    localparam logic [SMALL_W-1:0] SMALL_LIMIT_RESET = 16'd100;

    typedef struct packed {
        logic load;
        logic mul;
        logic pos;
        logic sq;
    } vgps_lane_ctrl_t;

endpackage

// ===== sv/vgps_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vgps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/vgps_lane.sv =====
// ----------------------------------------------------------------------------
// Voxel grid axis lane
// Maps one raw coordinate to its grid cell and the squared half-cell distance
// of its fraction from the cell centre, over four registered steps.
// ----------------------------------------------------------------------------
module vgps_lane
    import vgps_pkg::*;
(
    input  logic                        clk,
    input  vgps_lane_ctrl_t             ctrl,
    input  logic [COORD_W-1:0]          raw,
    input  logic [COORD_W-1:0]          origin,
    input  logic [SCALE_W-1:0]          scale,
    output logic [GRID_BITS-1:0]        cell_coord,
    output logic [SQ_W-1:0]             sq
);

    logic signed [COORD_W:0]     d_reg;
    logic signed [COORD_W:0]     d_next;
    logic [2*COORD_W-1:0]        lo_reg;
    logic [COORD_W+SCALE_HI_W-1:0] hi_reg;
    logic                        below_reg;
    logic [GRID_BITS-1:0]        cell_reg;
    logic [GRID_BITS-1:0]        cell_next;
    logic [AL_W-1:0]             al_reg;
    logic [AL_W-1:0]             al_next;
    logic [SQ_W-1:0]             sq_reg;
    logic [IP_W-1:0]             ip;
    logic [FRAC_BITS-1:0]        frac;
    logic [AL_W-1:0]             two_f;
    logic                        d_pos;

    assign d_next = {raw[COORD_W-1], raw} - {origin[COORD_W-1], origin};
    assign d_pos  = !d_reg[COORD_W] && (d_reg != '0);

    assign ip = {1'b0, hi_reg} + IP_W'(lo_reg[2*COORD_W-1:COORD_W]);

    always_comb
    begin
        if (below_reg)
        begin
            cell_next = '0;
            frac      = '0;
        end
        else if (ip >= (IP_W'(1) << GRID_BITS))
        begin
            // clamp to the box top: fraction zero
            cell_next = '1;
            frac      = '0;
        end
        else
        begin
            cell_next = ip[GRID_BITS-1:0];
            frac      = lo_reg[COORD_W-1 -: FRAC_BITS];
        end
        two_f = {frac, 1'b0};
        if (frac[FRAC_BITS-1])
        begin
            al_next = two_f - (AL_W'(1) << FRAC_BITS);
        end
        else
        begin
            al_next = (AL_W'(1) << FRAC_BITS) - two_f;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            d_reg <= d_next;
        end
        if (ctrl.mul)
        begin
            lo_reg    <= (2*COORD_W)'(d_reg[COORD_W-1:0])
                         * (2*COORD_W)'(scale[SCALE_FRAC-1:0]);
            hi_reg    <= (COORD_W+SCALE_HI_W)'(d_reg[COORD_W-1:0])
                         * (COORD_W+SCALE_HI_W)'(scale[SCALE_W-1:SCALE_FRAC]);
            below_reg <= !d_pos;
        end
        if (ctrl.pos)
        begin
            cell_reg <= cell_next;
            al_reg   <= al_next;
        end
        if (ctrl.sq)
        begin
            sq_reg <= SQ_W'(al_reg) * SQ_W'(al_reg);
        end
    end

    assign cell_coord = cell_reg;
    assign sq         = sq_reg;

endmodule

// ===== sv/voxel_grid_point_sampler_top.sv =====
// A point passes through ST_MUL, ST_POS, ST_SQ and ST_DEC, where it holds while
// the output register is full, before its result is registered for output. The
// stamp memory read-modify-write of each point completes before the next enters.
// Reset: registers take their defaults; the stamp memory is then zeroed one
// entry a cycle, all 2^21 (2097152) entries, during which no point is taken.
// ----------------------------------------------------------------------------
// Voxel grid point sampler
// Grid subsampling decision per point with a per-cell iteration stamp memory.
// ----------------------------------------------------------------------------
module voxel_grid_point_sampler_top
    import vgps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // x_raw[31:0], y_raw[63:32], z_raw[95:64], child_point_count[127:96]
    input  logic [127:0]          s_axis_tdata,
    // new_node[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // cell_index[20:0], zero fill [23:21]
    output logic [23:0]           m_axis_tdata,
    // accepted[0]
    output logic                  m_axis_tuser
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_POS   = 3'd3;
    localparam logic [2:0] ST_SQ    = 3'd4;
    localparam logic [2:0] ST_DEC   = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [CELL_BITS-1:0]   clr_addr_reg;
    logic [STAMP_WIDTH-1:0] iter_reg;
    logic [COORD_W-1:0]     origin_reg [3];
    logic [SCALE_W-1:0]     scale_reg [3];
    logic [LIMIT_W-1:0]     limit_reg;
    logic [SMALL_W-1:0]     small_lim_reg;
    logic                   small_reg;
    logic                   out_valid_reg;
    logic                   out_acc_reg;
    logic [CELL_BITS-1:0]   out_idx_reg;

    logic                   in_fire;
    logic                   out_load;
    vgps_lane_ctrl_t        lane_ctrl;
    logic [GRID_BITS-1:0]   cell_coord [3];
    logic [SQ_W-1:0]        sq [3];
    logic [CELL_BITS-1:0]   idx;
    logic [DSQ_W-1:0]       dsq;
    logic                   dist_ok;
    logic                   acc;
    logic                   ram_we;
    logic [CELL_BITS-1:0]   ram_waddr;
    logic [STAMP_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    logic [STAMP_WIDTH-1:0] ram_rdata;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_DEC) && (!out_valid_reg || m_axis_tready);

    assign lane_ctrl.load = in_fire;
    assign lane_ctrl.mul  = (state_reg == ST_MUL);
    assign lane_ctrl.pos  = (state_reg == ST_POS);
    assign lane_ctrl.sq   = (state_reg == ST_SQ);

    for (genvar a = 0; a < 3; a++)
    begin : g_lane
        vgps_lane u_lane (
            .clk        (clk),
            .ctrl       (lane_ctrl),
            .raw        (s_axis_tdata[a*COORD_W +: COORD_W]),
            .origin     (origin_reg[a]),
            .scale      (scale_reg[a]),
            .cell_coord (cell_coord[a]),
            .sq         (sq[a])
        );
    end

    assign idx     = {cell_coord[2], cell_coord[1], cell_coord[0]};
    assign dsq     = DSQ_W'(sq[0]) + DSQ_W'(sq[1]) + DSQ_W'(sq[2]);
    assign dist_ok = CMP_W'(dsq) < (CMP_W'(limit_reg) << FRAC_BITS);
    assign acc     = small_reg || (dist_ok && (ram_rdata != iter_reg));

    // Cell coordinates settle in ST_POS; fetch the stamp during ST_SQ
    assign ram_re    = (state_reg == ST_SQ);
    assign ram_we    = (state_reg == ST_CLEAR) || (out_load && acc);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : idx;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : iter_reg;

    vgps_ram #(
        .WIDTH (STAMP_WIDTH),
        .DEPTH (CELL_COUNT)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_POS;
            ST_POS:  state_next = ST_SQ;
            ST_SQ:   state_next = ST_DEC;
            ST_DEC:
            begin
                // hold until the output register is free
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                origin_reg[a] <= '0;
                scale_reg[a]  <= SCALE_RESET;
            end
            limit_reg     <= DIST_LIMIT_RESET;
            small_lim_reg <= SMALL_LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + CELL_BITS'(1);
            end
            if (in_fire)
            begin
                iter_reg <= iter_reg + STAMP_WIDTH'(s_axis_tuser);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ORIGIN_X:   origin_reg[0] <= cfg_data[COORD_W-1:0];
                    REG_ORIGIN_Y:   origin_reg[1] <= cfg_data[COORD_W-1:0];
                    REG_ORIGIN_Z:   origin_reg[2] <= cfg_data[COORD_W-1:0];
                    REG_SCALE_X:    scale_reg[0]  <= cfg_data[SCALE_W-1:0];
                    REG_SCALE_Y:    scale_reg[1]  <= cfg_data[SCALE_W-1:0];
                    REG_SCALE_Z:    scale_reg[2]  <= cfg_data[SCALE_W-1:0];
                    REG_DIST_LIMIT: limit_reg     <= cfg_data[LIMIT_W-1:0];
                    REG_SMALL_LIM:  small_lim_reg <= cfg_data[SMALL_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            small_reg <= s_axis_tdata[3*COORD_W +: COUNT_W] < COUNT_W'(small_lim_reg);
        end
        if (out_load)
        begin
            out_acc_reg <= acc;
            out_idx_reg <= idx;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_acc_reg;
    assign m_axis_tdata  = 24'(out_idx_reg);

    a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_axis_tready)
        else $error("point taken during stamp clearing");

    a_clear_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (ram_we && ram_wdata == '0))
        else $error("clearing pass skipped an entry");

    a_write_only_on_decision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg != ST_CLEAR) |-> (out_load && acc))
        else $error("stamp written without an accepted point");

    a_result_follows_decision: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_axis_tvalid)
        else $error("decision not presented");

    a_iter_moves_on_new_node: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_fire && s_axis_tuser) |=> $stable(iter_reg))
        else $error("iteration changed without a new node");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Voxel grid point sampler testbench
// Streams raw points through the sampler under several box, scale and limit
// settings, predicts each accept decision and cell index from a behavioural
// grid with its own stamp store, and checks every result transaction in order.
// Both stream sides idle in random bursts; a long output hold-off fills the
// block, and the final phase runs with no idling on either side.
// ----------------------------------------------------------------------------
module testbench
    import vgps_pkg::*;
;

    localparam int          STALL_LIMIT  = 3 * CELL_COUNT + 20000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          RANDOM_ITEMS = 220;
    localparam logic [SCALE_W-1:0] HALF_SCALE = 40'h00_8000_0000;
    localparam logic [SCALE_W-1:0] MAX_SCALE  = 40'hFF_FFFF_FFFF;
    localparam logic [LIMIT_W-1:0] MAX_LIMIT  = 18'd196608;

    typedef longint unsigned u64_t;

    typedef struct {
        logic signed [COORD_W-1:0] x_raw;
        logic signed [COORD_W-1:0] y_raw;
        logic signed [COORD_W-1:0] z_raw;
        logic [COUNT_W-1:0]        child_point_count;
        logic                      new_node;
    } point_t;

    typedef struct {
        logic                 accepted;
        logic [CELL_BITS-1:0] cell_index;
    } decision_t;

    class sampler_scoreboard;
        logic signed [COORD_W-1:0] origin [3];
        logic [SCALE_W-1:0]        scale [3];
        logic [LIMIT_W-1:0]        dist_limit;
        logic [SMALL_W-1:0]        small_limit;
        logic [STAMP_WIDTH-1:0]    iteration;
        logic [STAMP_WIDTH-1:0]    cell_stamps [int unsigned];
        decision_t                 pending_decisions [$];
        int                        failures;

        function new();
            for (int a = 0; a < 3; a++)
            begin
                origin[a] = '0;
                scale[a]  = SCALE_RESET;
            end
            dist_limit  = DIST_LIMIT_RESET;
            small_limit = SMALL_LIMIT_RESET;
            iteration   = '0;
            failures    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                REG_ORIGIN_X:   origin[0] = value[COORD_W-1:0];
                REG_ORIGIN_Y:   origin[1] = value[COORD_W-1:0];
                REG_ORIGIN_Z:   origin[2] = value[COORD_W-1:0];
                REG_SCALE_X:    scale[0] = value[SCALE_W-1:0];
                REG_SCALE_Y:    scale[1] = value[SCALE_W-1:0];
                REG_SCALE_Z:    scale[2] = value[SCALE_W-1:0];
                REG_DIST_LIMIT: dist_limit = value[LIMIT_W-1:0];
                REG_SMALL_LIM:  small_limit = value[SMALL_W-1:0];
                default: ;
            endcase
        endfunction

        // Position in cells with FRAC_BITS fraction bits, clamped to [0, grid size]
        function u64_t cell_position(logic signed [COORD_W-1:0] raw,
                                     logic signed [COORD_W-1:0] org,
                                     logic [SCALE_W-1:0] sc);
            longint d;
            u64_t   ud;
            u64_t   lo;
            u64_t   ip;
            d = longint'(raw) - longint'(org);
            if (d <= 0)
                return 0;
            ud = d;
            lo = ud * u64_t'(sc[SCALE_FRAC-1:0]);
            ip = ud * u64_t'(sc[SCALE_W-1:SCALE_FRAC]) + (lo >> 32);
            if (ip >= (64'd1 << GRID_BITS))
                return (64'd1 << GRID_BITS) << FRAC_BITS;
            return (ip << FRAC_BITS) | ((lo & 64'hFFFF_FFFF) >> (32 - FRAC_BITS));
        endfunction

        function void note_point(point_t p);
            logic signed [COORD_W-1:0] raw [3];
            logic [GRID_BITS-1:0]      cell_of [3];
            u64_t                      pos;
            u64_t                      axis_cell;
            u64_t                      al;
            u64_t                      dsq;
            longint                    l;
            logic [CELL_BITS-1:0]      idx;
            logic [STAMP_WIDTH-1:0]    stamp;
            decision_t                 d;
            raw[0] = p.x_raw;
            raw[1] = p.y_raw;
            raw[2] = p.z_raw;
            if (p.new_node)
                iteration = iteration + 1'b1;
            dsq = 0;
            for (int a = 0; a < 3; a++)
            begin
                pos       = cell_position(raw[a], origin[a], scale[a]);
                axis_cell = pos >> FRAC_BITS;
                l         = 2 * longint'(pos & ((64'd1 << FRAC_BITS) - 1))
                            - (longint'(1) << FRAC_BITS);
                al        = (l < 0) ? -l : l;
                if (axis_cell > (64'd1 << GRID_BITS) - 1)
                    axis_cell = (64'd1 << GRID_BITS) - 1;
                cell_of[a] = axis_cell[GRID_BITS-1:0];
                dsq += al * al;
            end
            idx   = {cell_of[2], cell_of[1], cell_of[0]};
            stamp = cell_stamps.exists(idx) ? cell_stamps[idx] : '0;
            if (p.child_point_count < COUNT_W'(small_limit))
                d.accepted = 1'b1;
            else
                d.accepted = (dsq < (u64_t'(dist_limit) << FRAC_BITS))
                             && (stamp != iteration);
            if (d.accepted)
                cell_stamps[idx] = iteration;
            d.cell_index = idx;
            pending_decisions.insert(pending_decisions.size(), d);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            failures++;
        endtask

        task check_result(logic accepted, logic [CELL_BITS-1:0] cell_index);
            decision_t d;
            if (pending_decisions.size() == 0)
            begin
                report($sformatf("unexpected result accepted=%b cell=%0d", accepted, cell_index));
                return;
            end
            d = pending_decisions[0];
            pending_decisions.delete(0);
            if (accepted !== d.accepted)
                report($sformatf("accepted %b, predicted %b (cell %0d)",
                                 accepted, d.accepted, d.cell_index));
            if (cell_index !== d.cell_index)
                report($sformatf("cell_index %0d, predicted %0d", cell_index, d.cell_index));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [127:0]          s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;
    logic                  m_axis_tuser;

    sampler_scoreboard board;
    int                send_gap_pct;
    int                take_gap_pct;
    logic              hold_off_req;
    logic              hold_off_done;
    int                quiet_cycles = 0;

    voxel_grid_point_sampler_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        board.set_reg(index, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction
    task automatic send_point(input point_t p);
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {p.child_point_count, p.z_raw, p.y_raw, p.x_raw};
        s_axis_tuser  = p.new_node;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_point(p);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (board.pending_decisions.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic point_t make_point(int x, int y, int z, logic [COUNT_W-1:0] cnt,
                                          logic nn);
        point_t p;
        p.x_raw             = x;
        p.y_raw             = y;
        p.z_raw             = z;
        p.child_point_count = cnt;
        p.new_node          = nn;
        return p;
    endfunction

    function automatic point_t random_point(int cluster_max);
        point_t                    p;
        logic signed [COORD_W-1:0] raw [3];
        u64_t                      off;
        int                        mode;
        mode = $urandom_range(0, 99);
        for (int a = 0; a < 3; a++)
        begin
            if (mode < 70 && board.scale[a] != 0)
            begin
                // land inside a chosen cell at a random fraction
                off = ((u64_t'($urandom_range(0, cluster_max)) << 32)
                       | u64_t'($urandom)) / board.scale[a];
                raw[a] = board.origin[a] + off[COORD_W-1:0];
            end
            else if (mode < 85)
                raw[a] = $urandom;
            else if ($urandom_range(0, 1) || board.scale[a] == 0)
                raw[a] = board.origin[a] + 32'($urandom_range(0, 6)) - 32'd3;
            else
            begin
                off = ((64'd1 << (GRID_BITS + 32)) / board.scale[a])
                      + u64_t'($urandom_range(0, 2));
                raw[a] = board.origin[a] + off[COORD_W-1:0] - 32'd1;
            end
        end
        p.x_raw = raw[0];
        p.y_raw = raw[1];
        p.z_raw = raw[2];
        case ($urandom_range(0, 9))
            0:          p.child_point_count = $urandom_range(0, 1) ? '0 : '1;
            1, 2, 3, 4: p.child_point_count = COUNT_W'(board.small_limit)
                                              + COUNT_W'($urandom_range(0, 3)) - 32'd2;
            default:    p.child_point_count = $urandom;
        endcase
        p.new_node = ($urandom_range(0, 15) == 0);
        return p;
    endfunction

    task automatic random_setup(input int ph);
        logic signed [COORD_W-1:0] org;
        u64_t                      sc;
        int                        e;
        logic [LIMIT_W-1:0]        lim;
        logic [SMALL_W-1:0]        sml;
        for (int a = 0; a < 3; a++)
        begin
            if (ph == 0)
                org = (a == 0) ? 32'sh8000_0000 : (a == 1) ? 32'sh7FFF_FFFF : 32'sh0;
            else
                org = $signed($urandom) >>> 2;
            write_reg(CFG_IDX_W'(REG_ORIGIN_X + a), {8'($urandom), org});
            e  = $urandom_range(20, 39);
            sc = (64'd1 << e) | ({$urandom, $urandom} & ((64'd1 << e) - 1));
            if (ph == 3 && a == 0)
                sc = 0;
            else if (ph == 3 && a == 2)
                sc = MAX_SCALE;
            write_reg(CFG_IDX_W'(REG_SCALE_X + a), sc[SCALE_W-1:0]);
        end
        lim = (ph == 2) ? '0 : (ph == 4) ? MAX_LIMIT : LIMIT_W'($urandom_range(30000, 196608));
        sml = (ph == 2) ? '1 : (ph == 4) ? '0 : SMALL_W'($urandom_range(0, 300));
        write_reg(REG_DIST_LIMIT, {22'($urandom), lim});
        write_reg(REG_SMALL_LIM, {24'($urandom), sml});
    endtask

    // Result side: random ready bursts, plus one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        hold_off_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_done = 1'b1;
            end
            else if ($urandom_range(0, 99) < take_gap_pct)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tuser, m_axis_tdata[CELL_BITS-1:0]);
    end

    // Watchdog: must outlast the stamp clearing pass after reset
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        board         = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        hold_off_req  = 1'b0;
        send_gap_pct  = 20;
        take_gap_pct  = 5;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Half-cell scale puts odd coordinates on cell centres
        for (int a = 0; a < 3; a++)
        begin
            write_reg(CFG_IDX_W'(REG_ORIGIN_X + a), '0);
            write_reg(CFG_IDX_W'(REG_SCALE_X + a), HALF_SCALE);
        end
        write_reg(REG_DIST_LIMIT, CFG_DATA_W'(DIST_LIMIT_RESET));
        write_reg(REG_SMALL_LIM, CFG_DATA_W'(SMALL_LIMIT_RESET));

        // no node started yet: only small children get through
        send_point(make_point(1, 1, 1, 32'd0, 1'b0));
        send_point(make_point(3, 3, 3, 32'd1000, 1'b0));
        // first node: centred point wins, repeat in the same cell loses
        send_point(make_point(3, 3, 3, 32'd1000, 1'b1));
        send_point(make_point(3, 3, 3, 32'd1000, 1'b0));
        send_point(make_point(3, 3, 3, 32'd99, 1'b0));
        send_point(make_point(-5, -5, -5, 32'd1000, 1'b0));
        send_point(make_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '1, 1'b0));
        send_point(make_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '0, 1'b0));
        send_point(make_point(255, 1, 255, 32'd1000, 1'b0));
        send_point(make_point(256, 256, 256, 32'd1000, 1'b0));
        send_point(make_point(2, 1, 1, 32'd1000, 1'b0));
        send_point(make_point(3, 3, 3, 32'd1000, 1'b1));
        send_point(make_point(5, 7, 9, 32'd100, 1'b0));

        // register extremes: zero and full scale, box at the coordinate limits
        drain_results();
        write_reg(REG_ORIGIN_X, CFG_DATA_W'(32'h7FFF_FFFF));
        write_reg(REG_ORIGIN_Y, CFG_DATA_W'(32'h8000_0000));
        write_reg(REG_ORIGIN_Z, '0);
        write_reg(REG_SCALE_X, '0);
        write_reg(REG_SCALE_Y, MAX_SCALE);
        write_reg(REG_DIST_LIMIT, CFG_DATA_W'(MAX_LIMIT));
        write_reg(REG_SMALL_LIM, '0);
        send_point(make_point(32'sh7FFF_FFFF, 32'sh8000_0001, 5, '0, 1'b1));
        send_point(make_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '1, 1'b0));
        send_point(make_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '1, 1'b1));
        send_point(make_point(-1, 0, 1, 32'd7, 1'b0));
        drain_results();
        write_reg(REG_SMALL_LIM, CFG_DATA_W'(16'hFFFF));
        send_point(make_point(0, 0, 0, 32'd65534, 1'b0));
        send_point(make_point(0, 0, 0, 32'd65535, 1'b0));

        for (int ph = 0; ph < 6; ph++)
        begin
            drain_results();
            random_setup(ph);
            send_gap_pct = (ph == 5) ? 0 : (ph == 2) ? 0 : (ph == 1) ? 40 : 15;
            take_gap_pct = send_gap_pct / 4;
            for (int i = 0; i < RANDOM_ITEMS; i++)
            begin
                if (ph == 1 && i == 60)
                    hold_off_req = 1'b1;
                if (ph == 3 && i == 110)
                    drain_results();
                send_point(random_point((ph % 2 == 0) ? 3 : (1 << GRID_BITS) - 1));
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (board.pending_decisions.size() != 0)
            board.report("results still outstanding at end of run");
        if (board.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
